// ===== hw/rtl/goldbach_pair_search_assert.svh =====
// ----------------------------------------------------------------------------
// Goldbach pair search assertion macros
// Shared property macros for the port-level checker. Each macro expects
// clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef GOLDBACH_PAIR_SEARCH_ASSERT_SVH
`define GOLDBACH_PAIR_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("goldbach_pair_search: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("goldbach_pair_search: next-cycle check failed");

`endif

// ===== hw/rtl/gps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Goldbach pair search package
// Widths, table depth and the shared types used across the block.
// ----------------------------------------------------------------------------
package gps_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int ENTRY_IDX_W = 8;
  localparam int DATA_W      = 16;
  localparam int NUM_W       = 17;
  localparam int SIZE_W      = 9;
  localparam int SIZE_RESET  = 200;

  // Action codes carried by a word on the input channel.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Request from the sequencer to the prime table.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } tbl_req_t;

  // Result of the shared compare and subtract unit.
  typedef struct packed {
    logic             eq;
    logic             gt;
    logic [NUM_W-1:0] diff;
  } alu_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/goldbach_pair_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Goldbach pair search
// Searches a loaded table of sorted primes for the first pair p + q = n.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid / in_stall    action, entry_index, entry_value,
//                                             query_number
//  out      output     out_valid / out_stall  found, first_part, second_part
//  cfg      input      cfg_wr_en              cfg_wr_data (table_size)
//
// A write word gives no result. A query reads and tests each scanned entry;
// an entry below n then runs a binary search, probe by probe (up to 9 probes),
// and closes the search; a last step loads the output register. The single
// table read port and the shared compare unit keep every step sequential.
// in_stall is high while a query is at work or its result waits for the
// output register. Reset is synchronous; it returns the sequencer to idle,
// sets the size register to 200 and clears output valid, but not the table.
// ----------------------------------------------------------------------------
module goldbach_pair_search (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [gps_pkg::SIZE_W-1:0]       cfg_wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_action,
  input  wire logic [gps_pkg::ENTRY_IDX_W-1:0]  in_entry_index,
  input  wire logic [gps_pkg::DATA_W-1:0]       in_entry_value,
  input  wire logic [gps_pkg::NUM_W-1:0]        in_query_number,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_found,
  output logic [gps_pkg::DATA_W-1:0]            out_first_part,
  output logic [gps_pkg::DATA_W-1:0]            out_second_part
);

  gps_pkg::tbl_req_t          tbl_req;
  logic [gps_pkg::DATA_W-1:0] tbl_rd_data;

  // Sequencer with the shared compare unit and the output register.
  gps_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_query_number (in_query_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_first_part  (out_first_part),
    .out_second_part (out_second_part),
    .tbl_req         (tbl_req),
    .tbl_rd_data     (tbl_rd_data)
  );

  // Prime table memory.
  gps_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd_data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/gps_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Prime table
// Single-port-write, single-port-read memory of table entries with a
// registered read.
// ----------------------------------------------------------------------------
module gps_table (
  input  wire logic                      clk,
  input  wire gps_pkg::tbl_req_t         req,
  output logic [gps_pkg::DATA_W-1:0]     rd_data
);

  logic [gps_pkg::DATA_W-1:0] mem [gps_pkg::TABLE_DEPTH];
  logic [gps_pkg::DATA_W-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/gps_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Compare and subtract unit
// Shared unit used for both the n > p test with n - p, and the binary
// search probe compare.
// ----------------------------------------------------------------------------
module gps_alu (
  input  wire logic [gps_pkg::NUM_W-1:0] op_a,
  input  wire logic [gps_pkg::NUM_W-1:0] op_b,
  output gps_pkg::alu_res_t              res
);

  // One subtractor with an extra bit gives both the difference and the order.
  logic [gps_pkg::NUM_W:0] sub;

  always_comb begin
    sub      = {1'b0, op_a} - {1'b0, op_b};
    res.diff = sub[gps_pkg::NUM_W-1:0];
    res.eq   = (op_a == op_b);
    res.gt   = !sub[gps_pkg::NUM_W] && !res.eq;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pair search sequencer
// Walks the table in index order and runs a binary search for n - p on each
// entry below n, using the shared compare unit. Holds the size register and the
// output register.
// ----------------------------------------------------------------------------
module gps_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [gps_pkg::SIZE_W-1:0]       cfg_wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_action,
  input  wire logic [gps_pkg::ENTRY_IDX_W-1:0]  in_entry_index,
  input  wire logic [gps_pkg::DATA_W-1:0]       in_entry_value,
  input  wire logic [gps_pkg::NUM_W-1:0]        in_query_number,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_found,
  output logic [gps_pkg::DATA_W-1:0]            out_first_part,
  output logic [gps_pkg::DATA_W-1:0]            out_second_part,
  output gps_pkg::tbl_req_t                     tbl_req,
  input  wire logic [gps_pkg::DATA_W-1:0]       tbl_rd_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P_RD,
    ST_P_CHK,
    ST_S_RD,
    ST_S_CMP,
    ST_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [gps_pkg::SIZE_W-1:0]   size_r, size_nxt;
  logic [gps_pkg::NUM_W-1:0]    n_r, n_nxt;
  logic [gps_pkg::NUM_W-1:0]    diff_r, diff_nxt;
  logic [gps_pkg::DATA_W-1:0]   p_r, p_nxt;
  logic [gps_pkg::IDX_W-1:0]    i_r, i_nxt;
  logic [gps_pkg::CNT_W-1:0]    lo_r, lo_nxt;
  logic [gps_pkg::CNT_W-1:0]    hi_r, hi_nxt;
  logic [gps_pkg::CNT_W-1:0]    mid_r, mid_nxt;
  logic                         res_found_r, res_found_nxt;
  logic [gps_pkg::DATA_W-1:0]   res_p_r, res_p_nxt;
  logic [gps_pkg::DATA_W-1:0]   res_d_r, res_d_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r, out_found_nxt;
  logic [gps_pkg::DATA_W-1:0]   out_first_r, out_first_nxt;
  logic [gps_pkg::DATA_W-1:0]   out_second_r, out_second_nxt;

  logic                         accept;
  logic [gps_pkg::CNT_W-1:0]    count;
  logic [gps_pkg::CNT_W-1:0]    mid;
  logic                         last;
  logic                         advance;
  logic                         load;
  logic [gps_pkg::NUM_W-1:0]    alu_a;
  gps_pkg::alu_res_t            alu_res;

  // Shared compare and subtract unit; the table word is always operand b.
  assign alu_a = (state_r == ST_P_CHK) ? n_r : diff_r;

  gps_alu u_alu (
    .op_a (alu_a),
    .op_b ({1'b0, tbl_rd_data}),
    .res  (alu_res)
  );

  // Handshake and derived counts.
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign count    = (32'(size_r) > gps_pkg::TABLE_DEPTH) ?
                    gps_pkg::CNT_W'(gps_pkg::TABLE_DEPTH) : gps_pkg::CNT_W'(size_r);
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign last     = (gps_pkg::CNT_W'(i_r) + gps_pkg::CNT_W'(1)) >= count;
  assign load     = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Table port: writes are taken straight from an accepted write word.
  always_comb begin
    tbl_req.we    = accept && (in_action == gps_pkg::ACT_WRITE) &&
                    (32'(in_entry_index) < gps_pkg::TABLE_DEPTH);
    tbl_req.waddr = gps_pkg::IDX_W'(in_entry_index);
    tbl_req.wdata = in_entry_value;
    tbl_req.raddr = (state_r == ST_S_RD) ? mid[gps_pkg::IDX_W-1:0] : i_r;
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = cfg_wr_en ? cfg_wr_data : size_r;
    n_nxt         = n_r;
    diff_nxt      = diff_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_found_nxt = res_found_r;
    res_p_nxt     = res_p_r;
    res_d_nxt     = res_d_r;
    advance       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == gps_pkg::ACT_QUERY)) begin
          n_nxt         = in_query_number;
          i_nxt         = '0;
          res_found_nxt = 1'b0;
          res_p_nxt     = '0;
          res_d_nxt     = '0;
          state_nxt     = (count == '0) ? ST_DONE : ST_P_RD;
        end
      end
      ST_P_RD: begin
        state_nxt = ST_P_CHK;
      end
      ST_P_CHK: begin
        p_nxt = tbl_rd_data;
        if (alu_res.gt) begin
          diff_nxt  = alu_res.diff;
          lo_nxt    = '0;
          hi_nxt    = count;
          state_nxt = ST_S_RD;
        end else begin
          advance = 1'b1;
        end
      end
      ST_S_RD: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid;
          state_nxt = ST_S_CMP;
        end else begin
          advance = 1'b1;
        end
      end
      ST_S_CMP: begin
        if (alu_res.eq) begin
          res_found_nxt = 1'b1;
          res_p_nxt     = p_r;
          res_d_nxt     = diff_r[gps_pkg::DATA_W-1:0];
          state_nxt     = ST_DONE;
        end else begin
          if (alu_res.gt) begin
            lo_nxt = mid_r + gps_pkg::CNT_W'(1);
          end else begin
            hi_nxt = mid_r;
          end
          state_nxt = ST_S_RD;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Move on to the next table entry, or finish with no pair.
    if (advance) begin
      if (last) begin
        state_nxt = ST_DONE;
      end else begin
        i_nxt     = i_r + gps_pkg::IDX_W'(1);
        state_nxt = ST_P_RD;
      end
    end
  end

  // Output register: loads a finished word, holds it while stalled.
  always_comb begin
    out_found_nxt  = load ? res_found_r : out_found_r;
    out_first_nxt  = load ? res_p_r : out_first_r;
    out_second_nxt = load ? res_d_r : out_second_r;
    out_valid_nxt  = load || (out_valid_r && out_stall);
  end

  // State, size register and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= gps_pkg::SIZE_W'(gps_pkg::SIZE_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r          <= n_nxt;
    diff_r       <= diff_nxt;
    p_r          <= p_nxt;
    i_r          <= i_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    res_found_r  <= res_found_nxt;
    res_p_r      <= res_p_nxt;
    res_d_r      <= res_d_nxt;
    out_found_r  <= out_found_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_first_part  = out_first_r;
  assign out_second_part = out_second_r;

endmodule
`default_nettype wire

// ===== hw/rtl/gps_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Goldbach pair search port checker
// Watches the top-level ports and flags sequencing slips; bound to the top.
// ----------------------------------------------------------------------------
`include "goldbach_pair_search_assert.svh"

module gps_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire logic                             in_action,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic                             out_found,
  input  wire logic [gps_pkg::DATA_W-1:0]       out_first_part,
  input  wire logic [gps_pkg::DATA_W-1:0]       out_second_part
);

  logic write_take;
  logic query_take;
  logic parts_zero;

  // Accepted words of each kind, and an all-zero result payload.
  assign write_take = in_valid && !in_stall && (in_action == gps_pkg::ACT_WRITE);
  assign query_take = in_valid && !in_stall && (in_action == gps_pkg::ACT_QUERY);
  assign parts_zero = (out_first_part == '0) && (out_second_part == '0);

  // A stalled result word stays offered.
  `GPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A word that reports no pair carries zero parts.
  `GPS_ASSERT_SAME(a_miss_zero, out_valid && !out_found, parts_zero)

  // A table write never produces a result word.
  `GPS_ASSERT_NEXT(a_write_silent, write_take && !out_valid, !out_valid)

  // An accepted query keeps the input side stalled while it runs.
  `GPS_ASSERT_NEXT(a_query_busy, query_take, in_stall)

endmodule

bind goldbach_pair_search gps_checker u_gps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_found       (out_found),
  .out_first_part  (out_first_part),
  .out_second_part (out_second_part)
);
`default_nettype wire

// ===== test/goldbach_pair_search_test.sv =====
// ----------------------------------------------------------------------------
// Goldbach pair search testbench
// Loads the prime table through the input channel, then sends query words
// under several table sizes. The testbench predicts every result from its
// own copy of the table and size, and checks each result word in order.
// ----------------------------------------------------------------------------
module goldbach_pair_search_test;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 35;
  localparam int HOLD_CYCLES   = 1500;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 64;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_WORDS   = 5;
  localparam int WIDE_WORDS    = 2;
  localparam int LOAD_MAX      = 8;
  localparam int TIMEOUT       = 32_000_000;

  // One expected result word.
  typedef struct packed {
    logic                       found;
    logic [gps_pkg::DATA_W-1:0] first_part;
    logic [gps_pkg::DATA_W-1:0] second_part;
  } pair_t;

  logic                            clk             = 1'b0;
  logic                            rst_n           = 1'b0;
  logic                            cfg_wr_en       = 1'b0;
  logic [gps_pkg::SIZE_W-1:0]      cfg_wr_data     = '0;
  logic                            in_valid        = 1'b0;
  logic                            in_stall;
  logic                            in_action       = gps_pkg::ACT_WRITE;
  logic [gps_pkg::ENTRY_IDX_W-1:0] in_entry_index  = '0;
  logic [gps_pkg::DATA_W-1:0]      in_entry_value  = '0;
  logic [gps_pkg::NUM_W-1:0]       in_query_number = '0;
  logic                            out_valid;
  logic                            out_stall       = 1'b0;
  logic                            out_found;
  logic [gps_pkg::DATA_W-1:0]      out_first_part;
  logic [gps_pkg::DATA_W-1:0]      out_second_part;

  // Shadow copy of the block's table and size register.
  logic [gps_pkg::DATA_W-1:0] shadow_table [gps_pkg::TABLE_DEPTH];
  logic [gps_pkg::SIZE_W-1:0] shadow_size;
  pair_t                      pending_pairs [$];

  bit          steady        = 1'b0;
  int unsigned holds_asked   = 0;
  int unsigned holds_done    = 0;
  int unsigned errors        = 0;
  int unsigned queries_sent  = 0;
  int unsigned writes_sent   = 0;
  int unsigned pairs_checked = 0;
  int unsigned pairs_found   = 0;
  int unsigned sizes_used    = 0;

  goldbach_pair_search dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_query_number (in_query_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_first_part  (out_first_part),
    .out_second_part (out_second_part)
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    #TIMEOUT;
    $display("*** FAILED ***");
    $finish;
  end

  // Half-open binary search over the entries in use.
  function automatic bit table_has(input logic [gps_pkg::NUM_W-1:0] want,
                                   input int unsigned count);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (want == {1'b0, shadow_table[mid[gps_pkg::IDX_W-1:0]]}) return 1'b1;
      if (want > {1'b0, shadow_table[mid[gps_pkg::IDX_W-1:0]]}) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  // Scans the table in index order and returns the first pair that sums to n.
  function automatic pair_t predict_pair(input logic [gps_pkg::NUM_W-1:0] number);
    pair_t                     pair;
    int unsigned               count;
    int unsigned               i;
    logic [gps_pkg::NUM_W-1:0] p;
    logic [gps_pkg::NUM_W-1:0] diff;
    pair = '0;
    count = (shadow_size > gps_pkg::TABLE_DEPTH) ? gps_pkg::TABLE_DEPTH : shadow_size;
    for (i = 0; i < count; i++) begin
      p = {1'b0, shadow_table[i[gps_pkg::IDX_W-1:0]]};
      if (number > p) begin
        diff = number - p;
        if (table_has(diff, count)) begin
          pair.found       = 1'b1;
          pair.first_part  = p[gps_pkg::DATA_W-1:0];
          pair.second_part = diff[gps_pkg::DATA_W-1:0];
          return pair;
        end
      end
    end
    return pair;
  endfunction

  // Sum of two entries in use, so that the query has at least one pair.
  function automatic logic [gps_pkg::NUM_W-1:0] pair_sum(input int unsigned count);
    logic [gps_pkg::IDX_W-1:0] ia;
    logic [gps_pkg::IDX_W-1:0] ib;
    logic [gps_pkg::NUM_W-1:0] a;
    logic [gps_pkg::NUM_W-1:0] b;
    ia = gps_pkg::IDX_W'($urandom_range(count - 1));
    ib = gps_pkg::IDX_W'($urandom_range(count - 1));
    a = {1'b0, shadow_table[ia]};
    b = {1'b0, shadow_table[ib]};
    return a + b;
  endfunction

  function automatic bit is_prime(input int unsigned v);
    int unsigned d;
    if (v < 2) return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Offers one word, holding valid high until it is accepted. Valid stays high
  // afterwards so that a following word can go out on the next edge.
  task automatic send_word(input logic action,
                           input logic [gps_pkg::ENTRY_IDX_W-1:0] index,
                           input logic [gps_pkg::DATA_W-1:0] value,
                           input logic [gps_pkg::NUM_W-1:0] number);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_action       <= action;
    in_entry_index  <= index;
    in_entry_value  <= value;
    in_query_number <= number;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (action == gps_pkg::ACT_WRITE) begin
      shadow_table[index] = value;
      writes_sent++;
    end else begin
      pending_pairs.push_back(predict_pair(number));
      queries_sent++;
    end
  endtask

  task automatic write_entry(input int unsigned index, input int unsigned value);
    send_word(gps_pkg::ACT_WRITE, index[gps_pkg::ENTRY_IDX_W-1:0],
              value[gps_pkg::DATA_W-1:0], gps_pkg::NUM_W'($urandom_range(17'h1FFFF)));
  endtask

  task automatic query(input int unsigned number);
    send_word(gps_pkg::ACT_QUERY, gps_pkg::ENTRY_IDX_W'($urandom_range(255)),
              gps_pkg::DATA_W'($urandom_range(16'hFFFF)), number[gps_pkg::NUM_W-1:0]);
  endtask

  // Waits until every result is in and a trailing write has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input int unsigned size);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size[gps_pkg::SIZE_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_size = size[gps_pkg::SIZE_W-1:0];
    sizes_used++;
  endtask

  // Fills entries 0 to count-1 with ascending values at a random spacing.
  task automatic load_sorted(input int unsigned count);
    int unsigned k;
    int unsigned step_max;
    int unsigned v;
    step_max = $urandom_range(65535 / count, 2);
    v = $urandom_range(step_max - 1);
    for (k = 0; k < count; k++) begin
      write_entry(k, v);
      v += $urandom_range(step_max, 1);
    end
  endtask

  // Random word for a phase: mostly queries that have a pair, some noise.
  task automatic random_word(input int unsigned count);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) write_entry($urandom_range(gps_pkg::TABLE_DEPTH - 1), $urandom_range(16'hFFFF));
    else if (pick < 30 || count == 0) query($urandom_range(17'h1FFFF));
    else if (pick < 40) query($urandom_range(255));
    else query(32'(pair_sum(count)));
  endtask

  // The receiver stalls at random, and holds off for a long stretch on request.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Each accepted result word is compared with the oldest expected pair.
  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $error("result word with no query waiting: found %0d, first_part %0d, second_part %0d",
               out_found, out_first_part, out_second_part);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (want.found) pairs_found++;
        if (out_found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_found);
          errors++;
        end
        if (out_first_part !== want.first_part) begin
          $error("first_part: expected %0d, actual %0d", want.first_part, out_first_part);
          errors++;
        end
        if (out_second_part !== want.second_part) begin
          $error("second_part: expected %0d, actual %0d", want.second_part, out_second_part);
          errors++;
        end
      end
    end
  end

  // Every entry gets the odd primes in ascending order.
  task automatic test_prime_load();
    int unsigned k;
    int unsigned v;
    v = 3;
    for (k = 0; k < gps_pkg::TABLE_DEPTH; k++) begin
      while (!is_prime(v)) v += 2;
      write_entry(k, v);
      v += 2;
    end
  endtask

  // Queries under the size left by reset, small and large numbers, odd and even.
  task automatic test_reset_size();
    query(0);
    query(1);
    query(3);
    query(6);
    query(100);
    query(101);
    query(17'h1FFFF);
  endtask

  // An empty table never finds a pair; a single entry pairs only with itself.
  task automatic test_empty_and_single();
    set_size(0);
    query(6);
    query(131070);
    set_size(1);
    query(6);
    query(7);
  endtask

  // A zero entry and a full-scale entry at both ends of the table.
  task automatic test_value_extremes();
    set_size(4);
    write_entry(0, 0);
    query(5);
    write_entry(0, 3);
    set_size(gps_pkg::TABLE_DEPTH);
    write_entry(gps_pkg::TABLE_DEPTH - 1, 16'hFFFF);
    query(131070);
  endtask

  // Sizes above the table depth behave as the full table.
  task automatic test_saturated_size();
    set_size(511);
    query(65538);
    query(6);
    set_size(gps_pkg::TABLE_DEPTH + 1);
    query(131070);
  endtask

  // The search must follow the plain binary search on an unsorted table.
  task automatic test_unsorted_table();
    set_size(6);
    write_entry(0, 97);
    write_entry(1, 3);
    write_entry(2, 61);
    write_entry(3, 5);
    write_entry(4, 89);
    write_entry(5, 11);
    query(100);
    query(16);
    query(150);
  endtask

  // The receiver holds off while queries keep coming, so the input stalls.
  // The first sixteen entries still hold the sorted primes.
  task automatic test_backpressure();
    int unsigned k;
    set_size(16);
    holds_asked++;
    for (k = 0; k < 8; k++) query(32'(pair_sum(16)));
  endtask

  // Phases of random words, each under a new size; one phase runs with no idling.
  task automatic test_random_phases();
    int unsigned phase;
    int unsigned k;
    int unsigned pick;
    int unsigned count;
    int unsigned words;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(99);
      if (pick < 8) set_size(0);
      else if (pick < 18) set_size($urandom_range(511, gps_pkg::TABLE_DEPTH));
      else set_size($urandom_range(32, 1));
      count = (shadow_size > gps_pkg::TABLE_DEPTH) ? gps_pkg::TABLE_DEPTH : shadow_size;
      steady = (phase == 3);
      if (count > 0 && count <= LOAD_MAX && $urandom_range(1) == 1) load_sorted(count);
      words = (count >= gps_pkg::TABLE_DEPTH) ? WIDE_WORDS : PHASE_WORDS;
      for (k = 0; k < words; k++) random_word(count);
    end
    wait_idle();
    steady = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    shadow_size = gps_pkg::SIZE_W'(gps_pkg::SIZE_RESET);
    test_prime_load();
    test_reset_size();
    test_empty_and_single();
    test_value_extremes();
    test_saturated_size();
    test_backpressure();
    test_unsorted_table();
    test_random_phases();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pairs.size() != 0) begin
      $error("%0d expected results never arrived", pending_pairs.size());
      errors++;
    end
    $display("Sent %0d table writes and %0d queries; checked %0d results, %0d with a pair.",
             writes_sent, queries_sent, pairs_checked, pairs_found);
    $display("Used %0d size settings: empty, single, saturated, unsorted and held-off output.",
             sizes_used);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== goldbach_pair_search.f =====
+incdir+hw/rtl
hw/rtl/gps_pkg.sv
hw/rtl/gps_table.sv
hw/rtl/gps_alu.sv
hw/rtl/gps_ctrl.sv
hw/rtl/goldbach_pair_search.sv
hw/rtl/gps_checker.sv
test/goldbach_pair_search_test.sv
